// ----- sv/depth_flash_pixel_shader_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader assertion macros
// Shared concurrent check macros; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef DEPTH_FLASH_PIXEL_SHADER_UNIT_MACROS_SVH
`define DEPTH_FLASH_PIXEL_SHADER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low
`define DFPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfps: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low
`define DFPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfps: next-cycle check failed");
`else
`define DFPS_ASSERT_IMP(lbl, ante, cons)
`define DFPS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/dfps_pkg.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader package
// Shared widths, types, register indexes and the falloff table.
// ---------------------------------------------------------------------------
package dfps_pkg;

	// Falloff table resolution (index grid is 2^IDX_BITS steps over 0..1)
	localparam int unsigned IDX_BITS  = 8;
	localparam int unsigned IDX_MAX   = 1 << IDX_BITS;
	localparam int unsigned IDX_W     = IDX_BITS + 1;
	// Divider: one quotient bit per stage, one extra bit to catch overflow
	localparam int unsigned DIV_STEPS = IDX_BITS + 2;
	localparam int unsigned NUM_W     = 17 + IDX_BITS;

	// Falloff in Q0.12, gain in Q.20
	localparam int unsigned FALL_FRAC = 12;
	localparam int unsigned FALL_W    = FALL_FRAC + 1;
	localparam int unsigned CFG_GAIN_W = 12;
	localparam int unsigned PROD_W    = CFG_GAIN_W + FALL_W;
	localparam int unsigned GAIN_W    = PROD_W + 1;
	localparam int unsigned GAIN_FRAC = FALL_FRAC + 8;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned MUL_W     = CHAN_W + GAIN_W;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_REACH  = 2'd2;

	// Configuration reset values
	localparam logic [CFG_GAIN_W-1:0] FLASH_GAIN_RST   = 12'd640;
	localparam logic [CFG_GAIN_W-1:0] AMBIENT_GAIN_RST = 12'd26;
	localparam logic [15:0]           FLASH_REACH_RST  = 16'd1500;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [NUM_W-1:0]     num_t;
	typedef logic [DIV_STEPS-1:0] quo_t;
	typedef logic [FALL_W-1:0]    fall_t;
	typedef logic [GAIN_W-1:0]    gain_t;

	localparam idx_t  IDX_TOP  = idx_t'(1) << IDX_BITS;
	localparam fall_t FALL_ONE = fall_t'(1) << FALL_FRAC;

	// One pixel's color; blue sits in the low byte
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	typedef fall_t fall_rom_t [IDX_MAX];

	// Integer quotient by shift and subtract, for building the table
	function automatic longint unsigned quot_u64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// exp(-6*d^2) for d = i/2^IDX_BITS: exp(-t/8) by a 16-term series in Q0.30,
	// squared three times, then rounded to Q0.12
	function automatic fall_t falloff_entry(input int unsigned i);
		longint unsigned u;
		longint unsigned term;
		longint unsigned y;
		longint          sm;
		longint unsigned k;
		int              s;
		u    = (64'd6 * longint'(i) * longint'(i)) << (27 - 2 * IDX_BITS);
		term = 64'd1 << 30;
		sm   = 64'sd1 << 30;
		for (k = 1; k <= 16; k++) begin
			term = quot_u64((term * u) >> 30, k);
			if (k[0])
				sm = sm - longint'(term);
			else
				sm = sm + longint'(term);
		end
		if (sm < 0)
			sm = 0;
		if (sm > (64'sd1 << 30))
			sm = 64'sd1 << 30;
		y = longint'(sm);
		for (s = 0; s < 3; s++)
			y = (y * y + (64'd1 << 29)) >> 30;
		return fall_t'((y + (64'd1 << 17)) >> 18);
	endfunction

	function automatic fall_rom_t build_fall_rom();
		fall_rom_t rom;
		for (int i = 0; i < IDX_MAX; i++)
			rom[i] = falloff_entry(i);
		return rom;
	endfunction

	localparam fall_rom_t FALL_ROM = build_fall_rom();
	// Far end of the grid (normalized depth 1.0 and beyond)
	localparam fall_t FALL_END = falloff_entry(IDX_MAX);

endpackage

// ----- sv/dfps_div.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader - depth index divider
// Rounds depth * 2^IDX_BITS / reach to nearest, one quotient bit per stage,
// and clamps the result to the top of the falloff grid.
// ---------------------------------------------------------------------------
module dfps_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  dfps_pkg::pix_t       up_pix,
	input  logic [15:0]          up_depth,
	input  logic [15:0]          reach,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output dfps_pkg::pix_t       dn_pix,
	output dfps_pkg::idx_t       dn_idx
);

`include "depth_flash_pixel_shader_unit_macros.svh"

	localparam int unsigned L = dfps_pkg::DIV_STEPS - 1;

	logic            vld_s1;
	dfps_pkg::num_t  num_s1;
	dfps_pkg::pix_t  pix_s1;
	logic            take_s1;

	// Divider stages: entry j resolves quotient bit DIV_STEPS-1-j
	logic            vld_s2  [dfps_pkg::DIV_STEPS];
	dfps_pkg::num_t  rem_s2  [dfps_pkg::DIV_STEPS];
	dfps_pkg::quo_t  quo_s2  [dfps_pkg::DIV_STEPS];
	dfps_pkg::pix_t  pix_s2  [dfps_pkg::DIV_STEPS];
	logic            take_s2 [dfps_pkg::DIV_STEPS];

	logic            vld_s3;
	dfps_pkg::idx_t  idx_s3;
	dfps_pkg::pix_t  pix_s3;
	logic            take_s3;
	dfps_pkg::idx_t  idx_clamp;

	// A stage takes new data when it is empty or its successor moves
	assign take_s3  = !vld_s3 || dn_ready;
	assign take_s1  = !vld_s1 || take_s2[0];
	assign up_ready = take_s1;

	// Build the rounded numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (take_s1)
			vld_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (take_s1 && up_valid) begin
			num_s1 <= {1'b0, up_depth, {dfps_pkg::IDX_BITS{1'b0}}}
				+ dfps_pkg::NUM_W'(reach[15:1]);
			pix_s1 <= up_pix;
		end
	end

	// Restoring division, one compare and subtract per stage
	for (genvar j = 0; j < dfps_pkg::DIV_STEPS; j++) begin : g_step
		localparam int unsigned SH = dfps_pkg::DIV_STEPS - 1 - j;

		logic            vld_prev;
		dfps_pkg::num_t  rem_prev;
		dfps_pkg::quo_t  quo_prev;
		dfps_pkg::pix_t  pix_prev;
		dfps_pkg::num_t  dvs;
		logic            hit;

		if (j == 0) begin : g_first
			assign vld_prev = vld_s1;
			assign rem_prev = num_s1;
			assign quo_prev = '0;
			assign pix_prev = pix_s1;
		end else begin : g_next
			assign vld_prev = vld_s2[j-1];
			assign rem_prev = rem_s2[j-1];
			assign quo_prev = quo_s2[j-1];
			assign pix_prev = pix_s2[j-1];
		end

		if (j == L) begin : g_last_take
			assign take_s2[j] = !vld_s2[j] || take_s3;
		end else begin : g_mid_take
			assign take_s2[j] = !vld_s2[j] || take_s2[j+1];
		end

		// A zero reach always hits the top bit and so saturates
		assign dvs = dfps_pkg::num_t'(reach) << SH;
		assign hit = rem_prev >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s2[j] <= 1'b0;
			else if (take_s2[j])
				vld_s2[j] <= vld_prev;
		end

		always_ff @(posedge clk) begin
			if (take_s2[j] && vld_prev) begin
				rem_s2[j] <= hit ? (rem_prev - dvs) : rem_prev;
				quo_s2[j] <= {quo_prev[dfps_pkg::DIV_STEPS-2:0], hit};
				pix_s2[j] <= pix_prev;
			end
		end
	end

	// Clamp to the far end of the grid
	always_comb begin
		if (quo_s2[L][dfps_pkg::DIV_STEPS-1]
				|| (quo_s2[L][dfps_pkg::IDX_W-1:0] > dfps_pkg::IDX_TOP))
			idx_clamp = dfps_pkg::IDX_TOP;
		else
			idx_clamp = quo_s2[L][dfps_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (take_s3)
			vld_s3 <= vld_s2[L];
	end

	always_ff @(posedge clk) begin
		if (take_s3 && vld_s2[L]) begin
			idx_s3 <= idx_clamp;
			pix_s3 <= pix_s2[L];
		end
	end

	assign dn_valid = vld_s3;
	assign dn_idx   = idx_s3;
	assign dn_pix   = pix_s3;

	`DFPS_ASSERT_IMP(a_idx_in_grid, vld_s3, idx_s3 <= dfps_pkg::IDX_TOP)
	`DFPS_ASSERT_NXT(a_last_step_holds, vld_s2[L] && !take_s3, vld_s2[L] && $stable(quo_s2[L]))

endmodule

// ----- sv/dfps_gain.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader - gain stages
// Looks up the falloff, scales it by the flash gain and adds the ambient gain.
// ---------------------------------------------------------------------------
module dfps_gain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  dfps_pkg::pix_t                    up_pix,
	input  dfps_pkg::idx_t                    up_idx,
	input  logic [dfps_pkg::CFG_GAIN_W-1:0]   flash_gain,
	input  logic [dfps_pkg::CFG_GAIN_W-1:0]   ambient_gain,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output dfps_pkg::pix_t                    dn_pix,
	output dfps_pkg::gain_t                   dn_gain
);

`include "depth_flash_pixel_shader_unit_macros.svh"

	logic                           vld_s1, vld_s2, vld_s3;
	logic                           take_s1, take_s2, take_s3;
	dfps_pkg::fall_t                fall_s1;
	logic [dfps_pkg::PROD_W-1:0]    prod_s2;
	dfps_pkg::gain_t                gain_s3;
	dfps_pkg::pix_t                 pix_s1, pix_s2, pix_s3;
	dfps_pkg::fall_t                fall_rd;

	assign take_s3  = !vld_s3 || dn_ready;
	assign take_s2  = !vld_s2 || take_s3;
	assign take_s1  = !vld_s1 || take_s2;
	assign up_ready = take_s1;

	// Table read; the far end of the grid has its own entry
	assign fall_rd = up_idx[dfps_pkg::IDX_BITS] ? dfps_pkg::FALL_END
		: dfps_pkg::FALL_ROM[up_idx[dfps_pkg::IDX_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (take_s1)
				vld_s1 <= up_valid;
			if (take_s2)
				vld_s2 <= vld_s1;
			if (take_s3)
				vld_s3 <= vld_s2;
		end
	end

	// Falloff lookup, flash product, ambient sum
	always_ff @(posedge clk) begin
		if (take_s1 && up_valid) begin
			fall_s1 <= fall_rd;
			pix_s1  <= up_pix;
		end
		if (take_s2 && vld_s1) begin
			prod_s2 <= dfps_pkg::PROD_W'(fall_s1) * dfps_pkg::PROD_W'(flash_gain);
			pix_s2  <= pix_s1;
		end
		if (take_s3 && vld_s2) begin
			gain_s3 <= dfps_pkg::GAIN_W'({ambient_gain, {dfps_pkg::FALL_FRAC{1'b0}}})
				+ dfps_pkg::GAIN_W'(prod_s2);
			pix_s3  <= pix_s2;
		end
	end

	assign dn_valid = vld_s3;
	assign dn_pix   = pix_s3;
	assign dn_gain  = gain_s3;

	`DFPS_ASSERT_IMP(a_fall_max_one, vld_s1, fall_s1 <= dfps_pkg::FALL_ONE)

endmodule

// ----- sv/dfps_shade.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader - channel shading
// Multiplies each channel by the gain, rounds half up and saturates to 255.
// ---------------------------------------------------------------------------
module dfps_shade (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  dfps_pkg::pix_t   up_pix,
	input  dfps_pkg::gain_t  up_gain,
	output logic             dn_valid,
	input  logic             dn_ready,
	output dfps_pkg::pix_t   dn_pix
);

`include "depth_flash_pixel_shader_unit_macros.svh"

	typedef logic [dfps_pkg::MUL_W-1:0] mul_t;

	localparam mul_t HALF = mul_t'(1) << (dfps_pkg::GAIN_FRAC - 1);

	logic            vld_s1, vld_s2;
	logic            take_s1, take_s2;
	mul_t            mul_b_s1, mul_g_s1, mul_r_s1;
	dfps_pkg::pix_t  pix_s2;

	// Round half up, drop the Q.20 fraction, saturate to a byte
	function automatic logic [dfps_pkg::CHAN_W-1:0] round_sat(input mul_t p);
		mul_t s;
		s = (p + HALF) >> dfps_pkg::GAIN_FRAC;
		if (s > mul_t'({dfps_pkg::CHAN_W{1'b1}}))
			return {dfps_pkg::CHAN_W{1'b1}};
		return s[dfps_pkg::CHAN_W-1:0];
	endfunction

	assign take_s2  = !vld_s2 || dn_ready;
	assign take_s1  = !vld_s1 || take_s2;
	assign up_ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_s1)
				vld_s1 <= up_valid;
			if (take_s2)
				vld_s2 <= vld_s1;
		end
	end

	// Channel products, then round into the output register
	always_ff @(posedge clk) begin
		if (take_s1 && up_valid) begin
			mul_b_s1 <= mul_t'(up_pix.blue)  * mul_t'(up_gain);
			mul_g_s1 <= mul_t'(up_pix.green) * mul_t'(up_gain);
			mul_r_s1 <= mul_t'(up_pix.red)   * mul_t'(up_gain);
		end
		if (take_s2 && vld_s1) begin
			pix_s2.blue  <= round_sat(mul_b_s1);
			pix_s2.green <= round_sat(mul_g_s1);
			pix_s2.red   <= round_sat(mul_r_s1);
		end
	end

	assign dn_valid = vld_s2;
	assign dn_pix   = pix_s2;

	`DFPS_ASSERT_NXT(a_take_fills_s1, up_valid && up_ready, vld_s1)

endmodule

// ----- sv/depth_flash_pixel_shader_unit.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader unit
// Brightens each pixel by a flash whose strength falls off with depth.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transaction: blue, green, red and a depth
//   in millimetres. m_axis returns the lit pixel, one transaction per input,
//   in input order. The cfg channel writes flash_gain (index 0), ambient_gain
//   (index 1) and flash_reach_mm (index 2); other indexes are ignored. Write
//   it only while no pixel is in flight; cfg_ready is always high.
//   Throughput: one pixel per clock while m_axis_tready is high. Each pixel
//   passes the divider, which resolves one quotient bit per stage, then the
//   table, gain and channel multiplier stages.
//   Reset clears every stage valid bit and loads the register defaults
//   (2.5, about 0.1, 1500 mm). When m_axis_tready is low, each stage holds
//   its data; empty stages still fill, so s_axis_tready drops only once the
//   whole pipeline is full.
// ---------------------------------------------------------------------------
module depth_flash_pixel_shader_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Pixel in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [39:0]                       s_axis_tdata,  // blue_in, green_in, red_in, depth_mm
	// Pixel out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,  // blue_out, green_out, red_out
	// Register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dfps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data
);

	logic [dfps_pkg::CFG_GAIN_W-1:0]  flash_gain_q;
	logic [dfps_pkg::CFG_GAIN_W-1:0]  ambient_gain_q;
	logic [15:0]                      flash_reach_q;

	dfps_pkg::pix_t   in_pix;
	logic             div_valid, div_ready;
	dfps_pkg::pix_t   div_pix;
	dfps_pkg::idx_t   div_idx;
	logic             gain_valid, gain_ready;
	dfps_pkg::pix_t   gain_pix;
	dfps_pkg::gain_t  gain_val;
	dfps_pkg::pix_t   out_pix;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_gain_q   <= dfps_pkg::FLASH_GAIN_RST;
			ambient_gain_q <= dfps_pkg::AMBIENT_GAIN_RST;
			flash_reach_q  <= dfps_pkg::FLASH_REACH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dfps_pkg::CFG_FLASH_GAIN: begin
					flash_gain_q <= cfg_data[dfps_pkg::CFG_GAIN_W-1:0];
				end
				dfps_pkg::CFG_AMBIENT_GAIN: begin
					ambient_gain_q <= cfg_data[dfps_pkg::CFG_GAIN_W-1:0];
				end
				dfps_pkg::CFG_FLASH_REACH: begin
					flash_reach_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Unpack the pixel; the color bytes line up with pix_t
	assign in_pix = s_axis_tdata[23:0];

	dfps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s_axis_tvalid),
		.up_ready (s_axis_tready),
		.up_pix   (in_pix),
		.up_depth (s_axis_tdata[39:24]),
		.reach    (flash_reach_q),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_pix   (div_pix),
		.dn_idx   (div_idx)
	);

	dfps_gain u_gain (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (div_valid),
		.up_ready     (div_ready),
		.up_pix       (div_pix),
		.up_idx       (div_idx),
		.flash_gain   (flash_gain_q),
		.ambient_gain (ambient_gain_q),
		.dn_valid     (gain_valid),
		.dn_ready     (gain_ready),
		.dn_pix       (gain_pix),
		.dn_gain      (gain_val)
	);

	dfps_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (gain_valid),
		.up_ready (gain_ready),
		.up_pix   (gain_pix),
		.up_gain  (gain_val),
		.dn_valid (m_axis_tvalid),
		.dn_ready (m_axis_tready),
		.dn_pix   (out_pix)
	);

	assign m_axis_tdata = out_pix;

endmodule

// ----- dv/dfps_pixel_checker.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader checker
// Watches the pixel and register channels, predicts each lit pixel from its
// own copy of the registers and falloff table, and compares every field of
// each output transaction with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfps_pixel_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [39:0]                    s_axis_tdata,  // blue_in, green_in, red_in, depth_mm
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [23:0]                    m_axis_tdata,  // blue_out, green_out, red_out
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [dfps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output int unsigned                    fail_count,
	output int unsigned                    pending
);

	// Register shadow
	logic [dfps_pkg::CFG_GAIN_W-1:0] flash_q48;
	logic [dfps_pkg::CFG_GAIN_W-1:0] ambient_q48;
	logic [15:0]                     reach_mm;

	// exp(-6*d^2) in Q0.12 over the depth grid, far end included
	int unsigned falloff_q12 [0:dfps_pkg::IDX_MAX];

	// Lit pixels still owed by the block, oldest first
	dfps_pkg::pix_t lit_pixels_q [$];
	dfps_pkg::pix_t want_pix;
	dfps_pkg::pix_t got_pix;

	// Series for exp(-t/8) in Q0.30, squared three times, rounded to Q0.12
	function automatic int unsigned falloff_q12_at(input int unsigned step);
		longint unsigned arg;
		longint unsigned tail;
		longint unsigned sq;
		longint          acc;
		int unsigned     n;
		arg  = (64'd6 * 64'(step) * 64'(step)) << (27 - 2 * dfps_pkg::IDX_BITS);
		tail = 64'd1 << 30;
		acc  = 64'sd1 << 30;
		for (n = 1; n <= 16; n++) begin
			tail = ((tail * arg) >> 30) / n;
			acc  = (n % 2 == 1) ? acc - longint'(tail) : acc + longint'(tail);
		end
		if (acc < 0)
			acc = 0;
		else if (acc > (64'sd1 << 30))
			acc = 64'sd1 << 30;
		sq = longint'(acc);
		repeat (3)
			sq = (sq * sq + (64'd1 << 29)) >> 30;
		return int'((sq + (64'd1 << 17)) >> 18);
	endfunction

	// Normalized depth rounded onto the grid; a zero reach means full distance
	function automatic int unsigned depth_grid_index(input logic [15:0] depth);
		longint unsigned q;
		if (reach_mm == 16'd0)
			return dfps_pkg::IDX_MAX;
		q = ((64'(depth) << dfps_pkg::IDX_BITS) + 64'(reach_mm >> 1)) / 64'(reach_mm);
		return (q > dfps_pkg::IDX_MAX) ? dfps_pkg::IDX_MAX : int'(q);
	endfunction

	// Scale one channel by a Q.20 gain, round half up, saturate
	function automatic logic [dfps_pkg::CHAN_W-1:0] lit_channel(
			input logic [dfps_pkg::CHAN_W-1:0] c, input longint unsigned gain);
		longint unsigned v;
		v = (64'(c) * gain + (64'd1 << 19)) >> 20;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic dfps_pkg::pix_t shade_pixel(input logic [39:0] word);
		longint unsigned gain;
		dfps_pkg::pix_t  lit;
		gain = (64'(ambient_q48) << 12)
			+ 64'(flash_q48) * 64'(falloff_q12[depth_grid_index(word[39:24])]);
		lit.blue  = lit_channel(word[7:0], gain);
		lit.green = lit_channel(word[15:8], gain);
		lit.red   = lit_channel(word[23:16], gain);
		return lit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	initial begin
		for (int i = 0; i <= dfps_pkg::IDX_MAX; i++)
			falloff_q12[i] = falloff_q12_at(i);
	end

	// Track register writes, predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_q48   <= dfps_pkg::FLASH_GAIN_RST;
			ambient_q48 <= dfps_pkg::AMBIENT_GAIN_RST;
			reach_mm    <= dfps_pkg::FLASH_REACH_RST;
			lit_pixels_q.delete();
			pending     <= 0;
			fail_count  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dfps_pkg::CFG_FLASH_GAIN:
						flash_q48   <= cfg_data[dfps_pkg::CFG_GAIN_W-1:0];
					dfps_pkg::CFG_AMBIENT_GAIN:
						ambient_q48 <= cfg_data[dfps_pkg::CFG_GAIN_W-1:0];
					dfps_pkg::CFG_FLASH_REACH:
						reach_mm    <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				lit_pixels_q.push_back(shade_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got_pix = m_axis_tdata;
				if (lit_pixels_q.size() == 0) begin
					report_mismatch($sformatf("lit pixel %h with no input pending", got_pix));
				end else begin
					want_pix = lit_pixels_q.pop_front();
					if (got_pix.blue !== want_pix.blue)
						report_mismatch($sformatf("blue_out got %0d, expected %0d",
							got_pix.blue, want_pix.blue));
					if (got_pix.green !== want_pix.green)
						report_mismatch($sformatf("green_out got %0d, expected %0d",
							got_pix.green, want_pix.green));
					if (got_pix.red !== want_pix.red)
						report_mismatch($sformatf("red_out got %0d, expected %0d",
							got_pix.red, want_pix.red));
				end
			end
			pending <= lit_pixels_q.size();
		end
	end

endmodule

// ----- dv/depth_flash_pixel_shader_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Depth flash pixel shader testbench
// Drives directed corner pixels and register settings, then random phases
// with random register values and random gaps on both streams; a checker
// beside the block predicts and compares every lit pixel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_flash_pixel_shader_unit_tb;

	localparam logic [dfps_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int unsigned DUT_LATENCY   = dfps_pkg::IDX_BITS + 9;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_PIXELS  = 100;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [39:0]                    s_axis_tdata  = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [23:0]                    m_axis_tdata;
	logic                           cfg_valid     = 1'b0;
	logic                           cfg_ready;
	logic [dfps_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
	logic [15:0]                    cfg_data      = '0;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned idle_odds  = 4;  // 0: no gaps or stalls
	int unsigned stall_left = 0;
	int unsigned cycles     = 0;
	logic [15:0] reach_now  = dfps_pkg::FLASH_REACH_RST;

	depth_flash_pixel_shader_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	dfps_pixel_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stall the output stream in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			stall_left    <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one pixel, maybe after a gap, and hold it until accepted
	task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
			input logic [7:0] red, input logic [15:0] depth);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {depth, red, green, blue};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [dfps_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == dfps_pkg::CFG_FLASH_REACH)
			reach_now = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every lit pixel is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Gain word: either fully random or a modest value with random upper bits
	function automatic logic [15:0] pick_gain(input int unsigned span);
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom);
		return {4'($urandom), 12'($urandom_range(0, span))};
	endfunction

	initial begin
		logic [15:0] depth;
		logic [23:0] rgb;
		int unsigned top_depth;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: color and depth extremes around the reach
		send_pixel(8'd0, 8'd0, 8'd0, 16'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 16'd0);
		send_pixel(8'd1, 8'd2, 8'd3, 16'd1);
		send_pixel(8'd100, 8'd50, 8'd200, 16'd750);
		send_pixel(8'd10, 8'd20, 8'd30, 16'd1499);
		send_pixel(8'd255, 8'd128, 8'd1, 16'd1500);
		send_pixel(8'd200, 8'd200, 8'd200, 16'h8000);
		send_pixel(8'h55, 8'hAA, 8'h0F, 16'hFFFF);
		drain();

		// Largest gains, smallest reach: any nonzero depth is full distance
		write_reg(dfps_pkg::CFG_FLASH_GAIN, 16'd4095);
		write_reg(dfps_pkg::CFG_AMBIENT_GAIN, 16'd4095);
		write_reg(dfps_pkg::CFG_FLASH_REACH, 16'd1);
		cfg_valid <= 1'b0;
		send_pixel(8'd1, 8'd255, 8'd0, 16'd0);
		send_pixel(8'd1, 8'd7, 8'd255, 16'd1);
		send_pixel(8'd0, 8'd1, 8'd16, 16'hFFFF);
		drain();

		// Zero gains, largest reach
		write_reg(dfps_pkg::CFG_FLASH_GAIN, 16'd0);
		write_reg(dfps_pkg::CFG_AMBIENT_GAIN, 16'd0);
		write_reg(dfps_pkg::CFG_FLASH_REACH, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_pixel(8'd255, 8'd255, 8'd255, 16'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 16'hFFFF);
		drain();

		// Zero reach acts as full distance; upper gain bits dropped; unmapped index ignored
		write_reg(dfps_pkg::CFG_FLASH_GAIN, 16'hF280);
		write_reg(dfps_pkg::CFG_AMBIENT_GAIN, 16'hF01A);
		write_reg(dfps_pkg::CFG_FLASH_REACH, 16'd0);
		write_reg(CFG_UNMAPPED, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_pixel(8'd255, 8'd128, 8'd64, 16'd0);
		send_pixel(8'd90, 8'd180, 8'd255, 16'd1234);
		send_pixel(8'd3, 8'd33, 8'd133, 16'hFFFF);
		drain();

		// Random phases, each with fresh register values; the last runs without gaps
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			idle_odds = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(2, 8);
			write_reg(dfps_pkg::CFG_FLASH_GAIN, pick_gain(1000));
			write_reg(dfps_pkg::CFG_AMBIENT_GAIN, pick_gain(300));
			case ($urandom_range(0, 3))
				0:       write_reg(dfps_pkg::CFG_FLASH_REACH, 16'($urandom_range(1, 64)));
				1:       write_reg(dfps_pkg::CFG_FLASH_REACH, 16'($urandom_range(65, 4000)));
				2:       write_reg(dfps_pkg::CFG_FLASH_REACH, 16'($urandom_range(1, 65535)));
				default: write_reg(dfps_pkg::CFG_FLASH_REACH, 16'($urandom));
			endcase
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_UNMAPPED, 16'($urandom));
			cfg_valid <= 1'b0;
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// Mostly depths near the reach, where the falloff moves
				top_depth = int'(reach_now) + int'(reach_now) / 4;
				if (top_depth > 65535)
					top_depth = 65535;
				if (reach_now != 0 && $urandom_range(0, 3) != 0)
					depth = 16'($urandom_range(0, top_depth));
				else
					depth = 16'($urandom);
				rgb = 24'($urandom);
				send_pixel(rgb[7:0], rgb[15:8], rgb[23:16], depth);
			end
		end
		drain();
		repeat (DUT_LATENCY + 4) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- depth_flash_pixel_shader_unit.f -----
+incdir+sv
sv/dfps_pkg.sv
sv/dfps_div.sv
sv/dfps_gain.sv
sv/dfps_shade.sv
sv/depth_flash_pixel_shader_unit.sv
dv/dfps_pixel_checker.sv
dv/depth_flash_pixel_shader_unit_tb.sv
